/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// checked only while reset is released
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* hw/rtl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types and constants of the rotation matrix to quaternion converter
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int MAG_W = 16;  // magnitude of one vector difference
    localparam int QW_W  = 15;  // scalar part width
    localparam int QB    = 17;  // quotient bits resolved by the divider
    localparam int LANES = 3;   // x, y, z

    localparam logic [QW_W-1:0]  QW_MAX    = 15'h7fff;
    localparam logic [MAG_W-1:0] Q_POS_SAT = 16'h7fff;
    localparam logic [MAG_W-1:0] Q_NEG_SAT = 16'h8000;

    // classified item: sign and magnitude per vector lane, plus usable flag
    typedef struct packed {
        logic                             pos;
        logic [LANES-1:0]                 neg;
        logic [LANES-1:0][MAG_W-1:0]      mag;
    } t_vec;

    // width of the positive radicand 1 + trace
    function automatic int rad_width(input int frac);
        rad_width = ((frac > 16) ? frac : 16) + 2;
    endfunction

endpackage

/* hw/rtl/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front
// accepts a matrix, forms 1 + trace and the three vector differences
// ----------------------------------------------------------------------------
module rmq_front #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic [8:0][15:0]                           i_mat,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output rmq_pkg::t_vec                              o_vec,
    output logic [rmq_pkg::rad_width(FRAC_BITS)-1:0]   o_rad
);
    import rmq_pkg::*;

    localparam int SW = rad_width(FRAC_BITS) + 1;

    logic signed [SW-1:0] c_one;
    logic signed [SW-1:0] c_sum;
    logic signed [16:0]   c_d [LANES];
    t_vec                 n_vec;
    logic                 r_valid;
    t_vec                 r_vec;
    logic [SW-2:0]        r_rad;

    assign c_one = {{(SW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    assign c_sum = c_one + SW'($signed(i_mat[0])) + SW'($signed(i_mat[4]))
                 + SW'($signed(i_mat[8]));

    // x: m21 - m12, y: m02 - m20, z: m10 - m01
    assign c_d[0] = 17'($signed(i_mat[7])) - 17'($signed(i_mat[5]));
    assign c_d[1] = 17'($signed(i_mat[2])) - 17'($signed(i_mat[6]));
    assign c_d[2] = 17'($signed(i_mat[3])) - 17'($signed(i_mat[1]));

    always_comb begin
        n_vec.pos = !c_sum[SW-1] && (c_sum != '0);
        for (int l = 0; l < LANES; l++) begin
            n_vec.neg[l] = c_d[l][16];
            n_vec.mag[l] = c_d[l][16] ? 16'(-c_d[l]) : c_d[l][15:0];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_vec <= n_vec;
            r_rad <= c_sum[SW-2:0];
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;
    assign o_rad   = r_rad;

endmodule

/* hw/rtl/rmq_fifo.sv */
// ----------------------------------------------------------------------------
// rmq_fifo
// small register queue between the front and the back
// ----------------------------------------------------------------------------
module rmq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic             push;
    logic             pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* hw/rtl/rmq_back.sv */
// ----------------------------------------------------------------------------
// rmq_back
// pipelined square root, three pipelined dividers and the output register
// ----------------------------------------------------------------------------
module rmq_back #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  rmq_pkg::t_vec                              i_vec,
    input  logic [rmq_pkg::rad_width(FRAC_BITS)-1:0]   i_rad,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic                                       o_valid_res,
    output logic [rmq_pkg::QW_W-1:0]                   o_qw,
    output logic [rmq_pkg::MAG_W-1:0]                  o_qx,
    output logic [rmq_pkg::MAG_W-1:0]                  o_qy,
    output logic [rmq_pkg::MAG_W-1:0]                  o_qz
);
    import rmq_pkg::*;

    localparam int RADW = rad_width(FRAC_BITS);
    localparam int NB   = RADW + FRAC_BITS;
    localparam int RW   = (NB + 1) / 2;
    localparam int NB2  = 2 * RW;
    localparam int WFW  = RW - 1;
    localparam int WXW  = (WFW > QW_W) ? WFW : QW_W;
    localparam int DENW = QW_W + 2;
    localparam int DW   = MAG_W + FRAC_BITS;
    localparam int CW   = (DW > DENW + QB) ? DW : DENW + QB;

    logic en;

    // square root stages, one root bit each
    logic            r_sq_v    [RW+1];
    t_vec            r_sq_vec  [RW+1];
    logic [RW+1:0]   r_sq_rem  [RW+1];
    logic [RW-1:0]   r_sq_root [RW+1];
    logic [NB2-1:0]  r_sq_rad  [RW+1];
    logic            n_sq_v    [RW+1];
    t_vec            n_sq_vec  [RW+1];
    logic [RW+1:0]   n_sq_rem  [RW+1];
    logic [RW-1:0]   n_sq_root [RW+1];
    logic [NB2-1:0]  n_sq_rad  [RW+1];

    // scalar stage
    logic            r_w_v;
    t_vec            r_w_vec;
    logic [QW_W-1:0] r_w_qw;
    logic [DENW-1:0] r_w_den;
    t_vec            n_w_vec;
    logic [QW_W-1:0] n_w_qw;
    logic [WFW-1:0]  c_wf;
    logic [WXW-1:0]  c_wx;

    // divider stages, one quotient bit each
    logic            r_dv_v   [QB+1];
    t_vec            r_dv_vec [QB+1];
    logic [QW_W-1:0] r_dv_qw  [QB+1];
    logic [DENW-1:0] r_dv_den [QB+1];
    logic [DW-1:0]   r_dv_rem [QB+1][LANES];
    logic [QB-1:0]   r_dv_q   [QB+1][LANES];
    logic            r_dv_ovf [QB+1][LANES];
    logic [DW-1:0]   n_dv_rem [QB+1][LANES];
    logic [QB-1:0]   n_dv_q   [QB+1][LANES];
    logic            n_dv_ovf [QB+1][LANES];

    // output register
    logic                   r_out_valid;
    logic                   r_res;
    logic [QW_W-1:0]        r_qw;
    logic [MAG_W-1:0]       r_q   [LANES];
    logic [MAG_W-1:0]       n_q   [LANES];

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    always_comb begin
        logic [RW+3:0] v_cur;
        logic [RW+3:0] v_trial;
        n_sq_v[0]    = i_valid;
        n_sq_vec[0]  = i_vec;
        n_sq_rem[0]  = '0;
        n_sq_root[0] = '0;
        n_sq_rad[0]  = NB2'(i_rad) << FRAC_BITS;
        for (int j = 0; j < RW; j++) begin
            v_cur   = {r_sq_rem[j], r_sq_rad[j][NB2-1 -: 2]};
            v_trial = {2'b00, r_sq_root[j], 2'b01};
            if (v_cur >= v_trial) begin
                n_sq_rem[j+1]  = (RW+2)'(v_cur - v_trial);
                n_sq_root[j+1] = {r_sq_root[j][RW-2:0], 1'b1};
            end else begin
                n_sq_rem[j+1]  = (RW+2)'(v_cur);
                n_sq_root[j+1] = {r_sq_root[j][RW-2:0], 1'b0};
            end
            n_sq_rad[j+1] = r_sq_rad[j] << 2;
            n_sq_v[j+1]   = r_sq_v[j];
            n_sq_vec[j+1] = r_sq_vec[j];
        end
    end

    // w = root / 2, clamped to the scalar range; zero w means no result
    assign c_wf = r_sq_root[RW][RW-1:1];
    assign c_wx = WXW'(c_wf);

    always_comb begin
        n_w_qw      = (c_wx > WXW'(QW_MAX)) ? QW_MAX : c_wx[QW_W-1:0];
        n_w_vec     = r_sq_vec[RW];
        n_w_vec.pos = r_sq_vec[RW].pos && (c_wf != '0);
    end

    always_comb begin
        logic [DW-1:0] v_num;
        logic [CW-1:0] v_sd;
        for (int l = 0; l < LANES; l++) begin
            v_num = DW'(r_w_vec.mag[l]) << FRAC_BITS;
            n_dv_ovf[0][l] = CW'(v_num) >= (CW'(r_w_den) << QB);
            n_dv_rem[0][l] = v_num;
            n_dv_q[0][l]   = '0;
        end
        for (int t = 0; t < QB; t++) begin
            for (int l = 0; l < LANES; l++) begin
                v_sd = CW'(r_dv_den[t]) << (QB - 1 - t);
                n_dv_ovf[t+1][l] = r_dv_ovf[t][l];
                if (CW'(r_dv_rem[t][l]) >= v_sd) begin
                    n_dv_rem[t+1][l] = DW'(CW'(r_dv_rem[t][l]) - v_sd);
                    n_dv_q[t+1][l]   = r_dv_q[t][l] | (QB'(1) << (QB - 1 - t));
                end else begin
                    n_dv_rem[t+1][l] = r_dv_rem[t][l];
                    n_dv_q[t+1][l]   = r_dv_q[t][l];
                end
            end
        end
    end

    // saturate to the signed range, zero when invalid
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (!r_dv_vec[QB].pos) begin
                n_q[l] = '0;
            end else if (r_dv_vec[QB].neg[l]) begin
                n_q[l] = (r_dv_ovf[QB][l] || r_dv_q[QB][l] > QB'(Q_NEG_SAT)) ?
                         Q_NEG_SAT : MAG_W'(-r_dv_q[QB][l]);
            end else begin
                n_q[l] = (r_dv_ovf[QB][l] || r_dv_q[QB][l] > QB'(Q_POS_SAT)) ?
                         Q_POS_SAT : r_dv_q[QB][l][MAG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= RW; j++) r_sq_v[j] <= 1'b0;
            for (int t = 0; t <= QB; t++) r_dv_v[t] <= 1'b0;
            r_w_v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            for (int j = 0; j <= RW; j++) r_sq_v[j] <= n_sq_v[j];
            r_w_v     <= r_sq_v[RW];
            r_dv_v[0] <= r_w_v;
            for (int t = 0; t < QB; t++) r_dv_v[t+1] <= r_dv_v[t];
            r_out_valid <= r_dv_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j <= RW; j++) begin
                r_sq_vec[j]  <= n_sq_vec[j];
                r_sq_rem[j]  <= n_sq_rem[j];
                r_sq_root[j] <= n_sq_root[j];
                r_sq_rad[j]  <= n_sq_rad[j];
            end
            r_w_vec <= n_w_vec;
            r_w_qw  <= n_w_qw;
            r_w_den <= {n_w_qw, 2'b00};
            r_dv_vec[0] <= r_w_vec;
            r_dv_qw[0]  <= r_w_qw;
            r_dv_den[0] <= r_w_den;
            for (int t = 0; t < QB; t++) begin
                r_dv_vec[t+1] <= r_dv_vec[t];
                r_dv_qw[t+1]  <= r_dv_qw[t];
                r_dv_den[t+1] <= r_dv_den[t];
            end
            for (int t = 0; t <= QB; t++) begin
                for (int l = 0; l < LANES; l++) begin
                    r_dv_rem[t][l] <= n_dv_rem[t][l];
                    r_dv_q[t][l]   <= n_dv_q[t][l];
                    r_dv_ovf[t][l] <= n_dv_ovf[t][l];
                end
            end
            r_res <= r_dv_vec[QB].pos;
            r_qw  <= r_dv_vec[QB].pos ? r_dv_qw[QB] : '0;
            for (int l = 0; l < LANES; l++) r_q[l] <= n_q[l];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_valid_res = r_res;
    assign o_qw        = r_qw;
    assign o_qx        = r_q[0];
    assign o_qy        = r_q[1];
    assign o_qz        = r_q[2];

endmodule

/* hw/rtl/rotation_matrix_to_quaternion.sv */
// RW = (max(FRAC_BITS,16) + 3 + FRAC_BITS) / 2 is the square root stage count
// throughput: one matrix per cycle while results are taken; the square root and
//   the three dividers are fully pipelined, one root or quotient bit per stage
// reset: synchronous, active low; clears all valid flags and the queue only
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// converts a Q1.14 rotation matrix into a unit quaternion, trace-positive
// branch only, with a decoupled front, a small queue and a pipelined back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS  = 14,
    parameter int FIFO_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_m00,
    input  logic signed [15:0] i_m01,
    input  logic signed [15:0] i_m02,
    input  logic signed [15:0] i_m10,
    input  logic signed [15:0] i_m11,
    input  logic signed [15:0] i_m12,
    input  logic signed [15:0] i_m20,
    input  logic signed [15:0] i_m21,
    input  logic signed [15:0] i_m22,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_valid_res,
    output logic [14:0]        o_qw,
    output logic signed [15:0] o_qx,
    output logic signed [15:0] o_qy,
    output logic signed [15:0] o_qz
);
    import rmq_pkg::*;

    localparam int RADW = rad_width(FRAC_BITS);
    localparam int FW   = $bits(t_vec) + RADW;

    logic [8:0][15:0] mat;

    // front -> queue
    logic             f_valid;
    logic             f_ready;
    t_vec             f_vec;
    logic [RADW-1:0]  f_rad;

    // queue -> back
    logic             q_valid;
    logic             q_ready;
    logic [FW-1:0]    q_data;
    t_vec             q_vec;
    logic [RADW-1:0]  q_rad;

    // all four quaternion parts at zero
    logic             out_zero;

    // matrix in row-major order, element 0 is m00
    assign mat = {i_m22, i_m21, i_m20, i_m12, i_m11, i_m10, i_m02, i_m01, i_m00};

    // front: takes a transaction each cycle its register is empty or the queue
    // has room; forms 1 + trace and sign/magnitude of the three vector differences
    rmq_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mat   (mat),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_vec   (f_vec),
        .o_rad   (f_rad)
    );

    // queue lets the front keep accepting while the back is held by the sink
    rmq_fifo #(
        .WIDTH (FW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_vec, f_rad}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    assign q_vec = q_data[FW-1:RADW];
    assign q_rad = q_data[RADW-1:0];

    // back: square root of (1 + trace) << FRAC_BITS, w = root / 2, then
    // diff << FRAC_BITS / 4w per lane, saturated; whole pipe advances while
    // the output register is empty or being taken
    rmq_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_ready     (q_ready),
        .i_vec       (q_vec),
        .i_rad       (q_rad),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_valid_res (o_valid_res),
        .o_qw        (o_qw),
        .o_qx        (o_qx),
        .o_qy        (o_qy),
        .o_qz        (o_qz)
    );

    assign out_zero = (o_qw == '0) && (o_qx == '0) && (o_qy == '0) && (o_qz == '0);

    // an invalid quaternion carries all-zero parts
    `ASSERT_RST(a_invalid_zero, i_clk, i_rst_n, (o_valid && !o_valid_res |-> out_zero), "invalid nonzero")

    // a valid quaternion never has a zero scalar part
    `ASSERT_RST(a_valid_w, i_clk, i_rst_n, (o_valid && o_valid_res |-> o_qw != '0), "zero scalar part")

    // nothing is presented right after a reset cycle
    `ASSERT_ALWAYS(a_reset_empty, i_clk, (!i_rst_n |=> !o_valid), "output valid after reset")

endmodule

/* dv/rotation_matrix_to_quaternion_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// drives Q1.14 rotation and arbitrary matrices into the converter with random gaps on both
// handshakes, predicts each quaternion with an independent integer model and
// compares every returned transaction in order
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;
    import rmq_pkg::*;

    localparam int FRAC           = 14;
    localparam longint ONE        = longint'(1) << FRAC;
    localparam int N_RANDOM       = 1450;
    localparam int TAIL_ITEMS     = 150;   // no new idle gaps on either side here
    localparam int DRAIN_EVERY    = 400;   // sender waits for an empty pipe
    localparam int SETTLE_CYCLES  = 80;    // quiet stretch after the last result
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // one matrix, row-major, slot 0 is m00 and slot 8 is m22
    typedef struct packed {
        logic             drain;
        logic [8:0][15:0] m;
    } t_mat_item;

    typedef struct packed {
        logic               valid_res;
        logic [14:0]        qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
    } t_quat;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_m00 = '0, i_m01 = '0, i_m02 = '0;
    logic signed [15:0] i_m10 = '0, i_m11 = '0, i_m12 = '0;
    logic signed [15:0] i_m20 = '0, i_m21 = '0, i_m22 = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_valid_res;
    logic [14:0]        o_qw;
    logic signed [15:0] o_qx, o_qy, o_qz;

    t_mat_item pending_matrices[$];
    t_quat     expected_quats[$];
    t_mat_item cur_matrix;

    int  n_matrices_sent = 0;   // driver side, blocking
    int  n_quats_seen    = 0;   // monitor side, nonblocking so the driver sees a stable value
    int  n_errors        = 0;
    int  n_rejected      = 0;
    int  n_saturated     = 0;
    int  send_gap        = 0;
    int  recv_gap        = 0;
    bit  send_idle_on    = 1'b1;
    bit  recv_idle_on    = 1'b1;
    logic tail_phase     = 1'b0;
    int  stall_cycles    = 0;

    rotation_matrix_to_quaternion u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_m00       (i_m00),
        .i_m01       (i_m01),
        .i_m02       (i_m02),
        .i_m10       (i_m10),
        .i_m11       (i_m11),
        .i_m12       (i_m12),
        .i_m20       (i_m20),
        .i_m21       (i_m21),
        .i_m22       (i_m22),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_valid_res (o_valid_res),
        .o_qw        (o_qw),
        .o_qx        (o_qx),
        .o_qy        (o_qy),
        .o_qz        (o_qz)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // quaternion predictor
    // ------------------------------------------------------------------------

    // largest root with root*root <= n, one bit at a time from the top
    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // diff / (4w) in Q1.14, truncated toward zero, clipped to the 16-bit range
    function automatic logic signed [15:0] clipped_ratio(input longint diff,
                                                         input longint den);
        longint mag;
        longint q;
        mag = (diff < 0) ? -diff : diff;
        q   = (mag << FRAC) / den;
        if (diff < 0)
            return (q >= 32768) ? Q_NEG_SAT : 16'(-q);
        return (q > 32767) ? Q_POS_SAT : 16'(q);
    endfunction

    function automatic longint elem(input t_mat_item it, input int idx);
        return longint'($signed(it.m[idx]));
    endfunction

    function automatic t_quat matrix_to_quat(input t_mat_item it);
        t_quat           q;
        longint          one_plus_trace;
        longint unsigned w;
        longint          den;
        q = '0;
        one_plus_trace = ONE + elem(it, 0) + elem(it, 4) + elem(it, 8);
        // one plus trace not positive: rejected, all fields zero
        if (one_plus_trace <= 0)
            return q;
        w = floor_root(longint'(one_plus_trace) << FRAC) >> 1;
        // w that floors to zero is rejected the same way
        if (w == 0)
            return q;
        if (w > QW_MAX)
            w = QW_MAX;
        den         = longint'(w) * 4;
        q.valid_res = 1'b1;
        q.qw        = 15'(w);
        q.qx        = clipped_ratio(elem(it, 7) - elem(it, 5), den);
        q.qy        = clipped_ratio(elem(it, 2) - elem(it, 6), den);
        q.qz        = clipped_ratio(elem(it, 3) - elem(it, 1), den);
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void add_matrix(input bit drain,
                                       input int e00, input int e01, input int e02,
                                       input int e10, input int e11, input int e12,
                                       input int e20, input int e21, input int e22);
        t_mat_item it;
        it.drain = drain;
        it.m[0] = 16'(e00); it.m[1] = 16'(e01); it.m[2] = 16'(e02);
        it.m[3] = 16'(e10); it.m[4] = 16'(e11); it.m[5] = 16'(e12);
        it.m[6] = 16'(e20); it.m[7] = 16'(e21); it.m[8] = 16'(e22);
        pending_matrices.push_back(it);
    endfunction

    function automatic int in_range();
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    function automatic void report_error(input string what);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("[%0t] error: %s", $realtime, what);
    endfunction

    // ------------------------------------------------------------------------
    // driver: one matrix per transaction, random bursts of idle cycles
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_quat want;
        logic  busy;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            busy = i_valid;
            if (i_valid && o_ready) begin
                want = matrix_to_quat(cur_matrix);
                expected_quats.push_back(want);
                n_matrices_sent++;
                if (!want.valid_res)
                    n_rejected++;
                if (want.qx == Q_POS_SAT || want.qx == Q_NEG_SAT ||
                    want.qy == Q_POS_SAT || want.qy == Q_NEG_SAT ||
                    want.qz == Q_POS_SAT || want.qz == Q_NEG_SAT)
                    n_saturated++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_matrices.size() > 0 &&
                             !(pending_matrices[0].drain &&
                               n_matrices_sent != n_quats_seen)) begin
                    // a marked matrix waits until the pipe has fully drained
                    cur_matrix = pending_matrices.pop_front();
                    i_m00 <= cur_matrix.m[0]; i_m01 <= cur_matrix.m[1];
                    i_m02 <= cur_matrix.m[2]; i_m10 <= cur_matrix.m[3];
                    i_m11 <= cur_matrix.m[4]; i_m12 <= cur_matrix.m[5];
                    i_m20 <= cur_matrix.m[6]; i_m21 <= cur_matrix.m[7];
                    i_m22 <= cur_matrix.m[8];
                    busy = 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        send_idle_on = !send_idle_on;
                    // gap applies after this transaction is taken
                    if (send_idle_on && !tail_phase && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 15);
                end
            end
            i_valid    <= busy;
            tail_phase <= (pending_matrices.size() < TAIL_ITEMS);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: in-order compare against the predicted quaternions
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_quat got;
        t_quat want;
        logic  rdy;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = '{o_valid_res, o_qw, o_qx, o_qy, o_qz};
                if (expected_quats.size() == 0) begin
                    report_error($sformatf({"unexpected result valid_res=%0b qw=%0d ",
                                            "qx=%0d qy=%0d qz=%0d"},
                                           got.valid_res, got.qw, got.qx, got.qy,
                                           got.qz));
                end else begin
                    want = expected_quats.pop_front();
                    if (got.valid_res !== want.valid_res || got.qw !== want.qw ||
                        got.qx !== want.qx || got.qy !== want.qy || got.qz !== want.qz)
                        report_error($sformatf({"mismatch exp valid_res=%0b qw=%0d qx=%0d ",
                                                "qy=%0d qz=%0d, got valid_res=%0b qw=%0d ",
                                                "qx=%0d qy=%0d qz=%0d"},
                                               want.valid_res, want.qw, want.qx, want.qy,
                                               want.qz, got.valid_res, got.qw, got.qx,
                                               got.qy, got.qz));
                end
                n_quats_seen <= n_quats_seen + 1;
            end
            // receiver back-pressure in bursts, none started during the tail
            if (recv_gap > 0) begin
                recv_gap--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if ($urandom_range(0, 199) == 0)
                    recv_idle_on = !recv_idle_on;
                if (recv_idle_on && !tail_phase && $urandom_range(0, 7) == 0)
                    recv_gap = $urandom_range(1, 15);
            end
            i_ready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: any long stretch without a transaction ends the run
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int  e[9];
        int  kind;
        int  qa, qb, qc, qd;
        longint aa, bb, cc, dd, nrm, delta;
        bit  drain;

        // directed part
        add_matrix(1'b0, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384);     // identity
        add_matrix(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0);                 // zero matrix, one plus trace is one
        add_matrix(1'b0, -16384, 0, 0, 0, -16384, 0, 0, 0, -16384);  // trace negative
        add_matrix(1'b0, -16384, 0, 0, 0, 0, 0, 0, 0, 0);            // one plus trace exactly zero
        add_matrix(1'b0, -16383, 0, 0, 0, 0, 0, 0, 0, 0);            // smallest positive radicand
        // smallest w with extreme differences: all three lanes clip
        add_matrix(1'b0, -16383, -32768, 32767, 32767, 0, 32767, -32768, -32768, 0);
        add_matrix(1'b0, -16383, 32767, -32768, -32768, 0, -32768, 32767, 32767, 0);
        add_matrix(1'b0, 16384, 0, 0, 0, 0, -16384, 0, 16384, 0);    // 90 deg about x
        add_matrix(1'b0, 0, 0, 16384, 0, 16384, 0, -16384, 0, 0);    // 90 deg about y
        add_matrix(1'b0, 0, -16384, 0, 16384, 0, 0, 0, 0, 16384);    // 90 deg about z
        add_matrix(1'b0, -16384, 0, 0, 0, -16384, 0, 0, 0, 16384);   // 180 deg about z
        add_matrix(1'b0, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384);
        add_matrix(1'b0, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_matrix(1'b0, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                   -32768);
        add_matrix(1'b0, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767);
        add_matrix(1'b0, 'h5555, 'h5555, 'h5555, 'h5555, 'h5555, 'h5555, 'h5555, 'h5555,
                   'h5555);
        add_matrix(1'b0, 'haaaa, 'haaaa, 'haaaa, 'haaaa, 'haaaa, 'haaaa, 'haaaa, 'haaaa,
                   'haaaa);
        add_matrix(1'b0, 32767, 5, -7, 9, -32768, 1, 3, -2, 1);     // out-of-range diagonal

        // random part, mostly genuine rotations from random integer quaternions
        for (int k = 0; k < N_RANDOM; k++) begin
            kind  = $urandom_range(0, 9);
            drain = (k % DRAIN_EVERY) == 0;
            if (kind <= 5) begin
                qa  = $urandom_range(0, 127);
                qb  = int'($urandom_range(0, 254)) - 127;
                qc  = int'($urandom_range(0, 254)) - 127;
                qd  = int'($urandom_range(0, 254)) - 127;
                aa  = qa * qa; bb = qb * qb; cc = qc * qc; dd = qd * qd;
                nrm = aa + bb + cc + dd;
                if (nrm == 0) begin
                    qa = 1; aa = 1; nrm = 1;
                end
                e[0] = int'((aa + bb - cc - dd) * ONE / nrm);
                e[1] = int'(2 * (qb * qc - qa * qd) * ONE / nrm);
                e[2] = int'(2 * (qb * qd + qa * qc) * ONE / nrm);
                e[3] = int'(2 * (qb * qc + qa * qd) * ONE / nrm);
                e[4] = int'((aa - bb + cc - dd) * ONE / nrm);
                e[5] = int'(2 * (qc * qd - qa * qb) * ONE / nrm);
                e[6] = int'(2 * (qb * qd - qa * qc) * ONE / nrm);
                e[7] = int'(2 * (qc * qd + qa * qb) * ONE / nrm);
                e[8] = int'((aa - bb - cc + dd) * ONE / nrm);
            end else if (kind <= 7) begin
                foreach (e[j])
                    e[j] = in_range();
            end else if (kind == 8) begin
                // raw 16-bit patterns, every bit of every field toggles
                foreach (e[j])
                    e[j] = int'($urandom_range(0, 65535));
            end else begin
                // radicand right around zero, off-diagonals anywhere
                foreach (e[j])
                    e[j] = int'($urandom_range(0, 65535));
                delta = longint'($urandom_range(0, 44)) - 4;
                e[0]  = int'($urandom_range(0, 16384)) - 8192;
                e[4]  = int'($urandom_range(0, 16384)) - 8192;
                e[8]  = int'(-ONE + delta - e[0] - e[4]);
            end
            add_matrix(drain, e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything taken, then everything returned, then a quiet stretch
        while (pending_matrices.size() != 0 || i_valid)
            @(posedge i_clk);
        while (expected_quats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (expected_quats.size() != 0)
            report_error($sformatf("%0d results never returned", expected_quats.size()));

        $display("run covered %0d matrices: %0d rejected, %0d with a clipped vector lane",
                 n_matrices_sent, n_rejected, n_saturated);
        $display("%0d quaternions checked, %0d errors", n_quats_seen, n_errors);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
